/* rtl/core/vms_pkg.sv */
// ----------------------------------------------------------------------------
// Vorticity magnitude stencil package
// Register indexes of the configuration port and the port's widths.
// ----------------------------------------------------------------------------
package vms_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THREE_DIM_MODE = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INV_DX         = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INV_DY         = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INV_DZ         = 8'd3;

    // Unsigned Q16.16 value of 1.0, the reset value of the inverse cell sizes.
    localparam logic [CFG_DATA_WIDTH-1:0] INV_ONE = 32'h0001_0000;

endpackage

/* rtl/core/vorticity_magnitude_stencil_unit.sv */
// Beats pass the difference, scale, curl, square, sum, root and output registers.
// Throughput: one beat per cycle; the pipeline moves as a whole whenever the
// output register is empty or being taken, so a stall holds every stage.
// The square root is one result bit per stage, which sets the depth.
// Reset (aresetn low, synchronous) empties the pipeline and sets 3-D mode and
// all inverse cell sizes to 1.0.
// ----------------------------------------------------------------------------
// Vorticity magnitude stencil unit
// Central-difference curl of a cell from twelve neighbor velocity samples,
// giving the curl magnitude in 3-D mode or the signed scalar in 2-D mode.
// ----------------------------------------------------------------------------
module vorticity_magnitude_stencil_unit #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vms_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [vms_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vy_at_xplus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vy_at_xminus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vz_at_xplus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vz_at_xminus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vx_at_yplus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vx_at_yminus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vz_at_yplus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vz_at_yminus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vx_at_zplus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vx_at_zminus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vy_at_zplus,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_vy_at_zminus,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        m_vorticity
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int DW  = W + 1;          // sample difference
    localparam int PW  = W + 34;         // difference times inverse size
    localparam int DRV = PW - 17;        // derivative after the halving shift
    localparam int CW  = DRV + 1;        // curl component
    localparam int QW  = W - 1;          // square root operand and root width
    localparam int SW  = 2 * W;          // sum of three squares
    localparam int NW  = 2 * W - 2;      // radicand
    localparam int RW  = W + 1;          // root remainder
    localparam int NS  = W - 1;          // root stages

    localparam logic signed [CW-1:0] OUT_MAX = CW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [CW-1:0] OUT_MIN = -OUT_MAX - CW'(1);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic        mode_reg;
    logic [31:0] inv_dx_reg;
    logic [31:0] inv_dy_reg;
    logic [31:0] inv_dz_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b1;
            inv_dx_reg <= vms_pkg::INV_ONE;
            inv_dy_reg <= vms_pkg::INV_ONE;
            inv_dz_reg <= vms_pkg::INV_ONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                vms_pkg::CFG_THREE_DIM_MODE: mode_reg   <= cfg_data[0];
                vms_pkg::CFG_INV_DX:         inv_dx_reg <= cfg_data;
                vms_pkg::CFG_INV_DY:         inv_dy_reg <= cfg_data;
                vms_pkg::CFG_INV_DZ:         inv_dz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------------
    // Stage 1: sample differences
    // ------------------------------------------------------------------------
    logic                 v1_reg;
    logic signed [DW-1:0] d1_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg[0] <= DW'(s_vy_at_xplus) - DW'(s_vy_at_xminus);  // vx
            d1_reg[1] <= DW'(s_vz_at_xplus) - DW'(s_vz_at_xminus);  // wx
            d1_reg[2] <= DW'(s_vx_at_yplus) - DW'(s_vx_at_yminus);  // uy
            d1_reg[3] <= DW'(s_vz_at_yplus) - DW'(s_vz_at_yminus);  // wy
            d1_reg[4] <= DW'(s_vx_at_zplus) - DW'(s_vx_at_zminus);  // uz
            d1_reg[5] <= DW'(s_vy_at_zplus) - DW'(s_vy_at_zminus);  // vz
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: scale by inverse cell size
    // ------------------------------------------------------------------------
    logic                 v2_reg;
    logic signed [PW-1:0] p2_reg [6];
    logic signed [PW-1:0] inv_ext [6];

    always_comb begin
        inv_ext[0] = PW'($signed({1'b0, inv_dx_reg}));
        inv_ext[1] = PW'($signed({1'b0, inv_dx_reg}));
        inv_ext[2] = PW'($signed({1'b0, inv_dy_reg}));
        inv_ext[3] = PW'($signed({1'b0, inv_dy_reg}));
        inv_ext[4] = PW'($signed({1'b0, inv_dz_reg}));
        inv_ext[5] = PW'($signed({1'b0, inv_dz_reg}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 6; i++) begin
                p2_reg[i] <= PW'(d1_reg[i]) * inv_ext[i];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: derivatives (floor of half the product), curl components
    // ------------------------------------------------------------------------
    logic signed [DRV-1:0] drv [6];
    logic signed [CW-1:0]  curl [3];
    logic        [CW-1:0]  mag [3];
    logic signed [W-1:0]   flat_val;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            drv[i] = DRV'(p2_reg[i] >>> 17);
        end
        curl[0] = CW'(drv[3]) - CW'(drv[5]);   // wy - vz
        curl[1] = CW'(drv[4]) - CW'(drv[1]);   // uz - wx
        curl[2] = CW'(drv[0]) - CW'(drv[2]);   // vx - uy
        for (int i = 0; i < 3; i++) begin
            mag[i] = curl[i][CW-1] ? CW'(-curl[i]) : CW'(curl[i]);
        end
        if (curl[2] > OUT_MAX) begin
            flat_val = W'(OUT_MAX);
        end else if (curl[2] < OUT_MIN) begin
            flat_val = W'(OUT_MIN);
        end else begin
            flat_val = W'(curl[2]);
        end
    end

    logic                v3_reg;
    logic                mode3_reg;
    logic                big3_reg;
    logic [QW-1:0]       c3_reg [3];
    logic signed [W-1:0] flat3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    // A component of at least 2^(W-1) alone pushes the root past the output range.
    always_ff @(posedge aclk) begin
        if (adv) begin
            mode3_reg <= mode_reg;
            big3_reg  <= (mag[0][CW-1:QW] != '0) || (mag[1][CW-1:QW] != '0) ||
                         (mag[2][CW-1:QW] != '0);
            for (int i = 0; i < 3; i++) begin
                c3_reg[i] <= mag[i][QW-1:0];
            end
            flat3_reg <= flat_val;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: squares
    // ------------------------------------------------------------------------
    logic                v4_reg;
    logic                mode4_reg;
    logic                big4_reg;
    logic [NW-1:0]       sq4_reg [3];
    logic signed [W-1:0] flat4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mode4_reg <= mode3_reg;
            big4_reg  <= big3_reg;
            flat4_reg <= flat3_reg;
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= NW'(c3_reg[i]) * NW'(c3_reg[i]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: sum of squares and range check
    // ------------------------------------------------------------------------
    logic [SW-1:0] sum_val;
    assign sum_val = SW'(sq4_reg[0]) + SW'(sq4_reg[1]) + SW'(sq4_reg[2]);

    logic                sq_v_reg    [NS+1];
    logic                sq_mode_reg [NS+1];
    logic                sq_byp_reg  [NS+1];
    logic signed [W-1:0] sq_bval_reg [NS+1];
    logic [NW-1:0]       sq_n_reg    [NS+1];
    logic [RW-1:0]       sq_rem_reg  [NS+1];
    logic [QW-1:0]       sq_root_reg [NS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_v_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_mode_reg[0] <= mode4_reg;
            sq_byp_reg[0]  <= !mode4_reg || big4_reg || (sum_val[SW-1:NW] != '0);
            sq_bval_reg[0] <= mode4_reg ? W'(OUT_MAX) : flat4_reg;
            sq_n_reg[0]    <= sum_val[NW-1:0];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    // ------------------------------------------------------------------------
    // Square root: one root bit per stage, restoring digit recurrence
    // ------------------------------------------------------------------------
    for (genvar k = 1; k <= NS; k++) begin : g_root
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          take;

        assign rem_sh = {sq_rem_reg[k-1][RW-3:0], sq_n_reg[k-1][NW-1 -: 2]};
        assign trial  = {sq_root_reg[k-1], 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[k] <= sq_v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_mode_reg[k] <= sq_mode_reg[k-1];
                sq_byp_reg[k]  <= sq_byp_reg[k-1];
                sq_bval_reg[k] <= sq_bval_reg[k-1];
                sq_n_reg[k]    <= {sq_n_reg[k-1][NW-3:0], 2'b00};
                sq_rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                sq_root_reg[k] <= {sq_root_reg[k-1][QW-2:0], take};
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic                out_v_reg;
    logic                out_mode_reg;
    logic signed [W-1:0] out_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= sq_v_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_mode_reg <= sq_mode_reg[NS];
            out_val_reg  <= sq_byp_reg[NS] ? sq_bval_reg[NS]
                                           : $signed({1'b0, sq_root_reg[NS]});
        end
    end

    assign m_valid     = out_v_reg;
    assign m_vorticity = out_val_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !v1_reg && !sq_v_reg[0])
        else $error("pipeline not empty after reset");

    a_magnitude_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && out_mode_reg |-> !m_vorticity[W-1])
        else $error("3-D magnitude is negative");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v1_reg) && $stable(v4_reg) && $stable(sq_v_reg[NS]))
        else $error("stage valid changed during a stall");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// Vorticity stencil unit testbench
// Drives neighbor velocity samples through the valid/ready input channel
// under several inverse cell size and mode settings, predicts each curl
// result in exact wide arithmetic, and checks every output beat in order.
// The sender works in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SW          = 32;
    localparam int PIPE_DEPTH  = SW + 5;
    localparam int IDLE_LIMIT  = 4000;

    typedef struct packed {
        logic [11:0][SW-1:0] smp;
    } stencil_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [vms_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [vms_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    stencil_t cur_cell = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SW-1:0] m_vorticity;

    // Shadow copy of the block's registers.
    logic        mode_3d = 1'b1;
    logic [31:0] inv_x = vms_pkg::INV_ONE;
    logic [31:0] inv_y = vms_pkg::INV_ONE;
    logic [31:0] inv_z = vms_pkg::INV_ONE;

    stencil_t             cell_queue[$];
    logic signed [SW-1:0] curl_queue[$];
    int err_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int cycle_cnt = 0;
    int idle_cycles = 0;

    always #4 aclk = ~aclk;

    vorticity_magnitude_stencil_unit #(.SAMPLE_WIDTH(SW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_vy_at_xplus(cur_cell.smp[0]), .s_vy_at_xminus(cur_cell.smp[1]),
        .s_vz_at_xplus(cur_cell.smp[2]), .s_vz_at_xminus(cur_cell.smp[3]),
        .s_vx_at_yplus(cur_cell.smp[4]), .s_vx_at_yminus(cur_cell.smp[5]),
        .s_vz_at_yplus(cur_cell.smp[6]), .s_vz_at_yminus(cur_cell.smp[7]),
        .s_vx_at_zplus(cur_cell.smp[8]), .s_vx_at_zminus(cur_cell.smp[9]),
        .s_vy_at_zplus(cur_cell.smp[10]), .s_vy_at_zminus(cur_cell.smp[11]),
        .m_valid(m_valid), .m_ready(m_ready), .m_vorticity(m_vorticity)
    );

    // Half central difference scaled by the inverse size, floored to Q16.16.
    function automatic logic signed [79:0] half_grad(logic [SW-1:0] plus,
                                                     logic [SW-1:0] minus,
                                                     logic [31:0] inv);
        logic signed [79:0] d;
        logic signed [79:0] p;
        d = $signed(plus) - $signed(minus);
        p = d * $signed({48'b0, inv});
        return p >>> 17;
    endfunction

    function automatic logic [63:0] abs_gap(logic signed [79:0] a,
                                            logic signed [79:0] b);
        logic signed [79:0] t;
        t = a - b;
        return (t < 0) ? 64'(-t) : 64'(t);
    endfunction

    function automatic logic signed [SW-1:0] curl_of(stencil_t c);
        logic signed [79:0] dvdx, dudy, dwdx, dwdy, dudz, dvdz, diff;
        logic [127:0] c1, c2, c3, sum, cand;
        logic [63:0] root;
        dvdx = half_grad(c.smp[0], c.smp[1], inv_x);
        dudy = half_grad(c.smp[4], c.smp[5], inv_y);
        if (!mode_3d) begin
            diff = dvdx - dudy;
            if (diff > 80'sh7FFF_FFFF) return 32'h7FFF_FFFF;
            if (diff < -80'sh8000_0000) return 32'h8000_0000;
            return diff[SW-1:0];
        end
        dwdx = half_grad(c.smp[2], c.smp[3], inv_x);
        dwdy = half_grad(c.smp[6], c.smp[7], inv_y);
        dudz = half_grad(c.smp[8], c.smp[9], inv_z);
        dvdz = half_grad(c.smp[10], c.smp[11], inv_z);
        c1 = 128'(abs_gap(dwdy, dvdz));
        c2 = 128'(abs_gap(dudz, dwdx));
        c3 = 128'(abs_gap(dvdx, dudy));
        sum = c1 * c1 + c2 * c2 + c3 * c3;
        if (sum >= (128'd1 << (2 * SW - 2))) return 32'h7FFF_FFFF;
        root = '0;
        for (int b = SW - 2; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= sum) root = cand[63:0];
        end
        return root[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] rand_sample(int flavor);
        case (flavor)
            0: return $urandom();
            1: return $urandom_range(0, 2 ** 21) - 2 ** 20;
            2: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 15) - 8;
        endcase
    endfunction

    function automatic stencil_t rand_cell();
        stencil_t c;
        int flavor;
        flavor = $urandom_range(0, 9);
        flavor = (flavor < 4) ? 0 : (flavor < 8) ? 1 : (flavor < 9) ? 2 : 3;
        for (int i = 0; i < 12; i++) c.smp[i] = rand_sample(flavor);
        return c;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) curl_queue.push_back(curl_of(cur_cell));
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (cell_queue.size() > 0) begin
                    cur_cell <= cell_queue.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall behavior switches among four patterns, chosen at random.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 200 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= (cycle_cnt % 7) < 2;
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (curl_queue.size() == 0) begin
                $error("unexpected result beat: vorticity %0d", m_vorticity);
                err_count++;
            end else begin
                logic signed [SW-1:0] want;
                want = curl_queue.pop_front();
                if (m_vorticity !== want) begin
                    $error("vorticity: expected %0d, actual %0d", want, m_vorticity);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [vms_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            vms_pkg::CFG_THREE_DIM_MODE: mode_3d = val[0];
            vms_pkg::CFG_INV_DX: inv_x = val;
            vms_pkg::CFG_INV_DY: inv_y = val;
            vms_pkg::CFG_INV_DZ: inv_z = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic m, logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
        write_reg(vms_pkg::CFG_THREE_DIM_MODE, {31'b0, m});
        write_reg(vms_pkg::CFG_INV_DX, ix);
        write_reg(vms_pkg::CFG_INV_DY, iy);
        write_reg(vms_pkg::CFG_INV_DZ, iz);
    endtask

    task automatic drain();
        while (cell_queue.size() > 0 || s_valid || curl_queue.size() > 0)
            @(posedge aclk);
        repeat (PIPE_DEPTH + 8) @(posedge aclk);
    endtask

    task automatic push_uniform(logic [SW-1:0] plus, logic [SW-1:0] minus);
        stencil_t c;
        for (int i = 0; i < 12; i++) c.smp[i] = (i % 2 == 0) ? plus : minus;
        cell_queue.push_back(c);
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++) cell_queue.push_back(rand_cell());
    endtask

    initial begin
        stencil_t c;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed cells at reset settings: zeros, extremes, floor rounding.
        push_uniform(32'h0, 32'h0);
        push_uniform(32'h7FFF_FFFF, 32'h8000_0000);
        push_uniform(32'h8000_0000, 32'h7FFF_FFFF);
        push_uniform(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_uniform(32'h0000_0001, 32'h0000_0000);
        push_uniform(32'h0000_0000, 32'h0000_0001);
        push_uniform(32'hFFFF_FFFF, 32'h0000_0000);
        c = '0;
        c.smp[0] = 32'h0003_0000;
        cell_queue.push_back(c);
        c = '0;
        c.smp[9] = 32'h0001_0001;
        cell_queue.push_back(c);
        push_random(40);
        drain();

        // Largest x and y inverse sizes in both modes, so both saturations are reached.
        set_regs(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_uniform(32'h0000_0001, 32'h0000_0000);
        push_uniform(32'h7FFF_FFFF, 32'h8000_0000);
        push_random(45);
        drain();
        set_regs(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        push_uniform(32'h7FFF_FFFF, 32'h8000_0000);
        push_uniform(32'h8000_0000, 32'h7FFF_FFFF);
        c = '0;
        c.smp[4] = 32'h7FFF_FFFF;
        c.smp[5] = 32'h8000_0000;
        cell_queue.push_back(c);
        c = '0;
        c.smp[0] = 32'h0000_0003;
        cell_queue.push_back(c);
        push_random(45);
        drain();

        // Zero inverse sizes kill every derivative; a 2-D run then mixes zero, unit and largest sizes.
        set_regs(1'b1, 32'h0, 32'h0, 32'h0);
        push_random(30);
        drain();
        set_regs(1'b0, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF);
        push_random(30);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            set_regs(1'($urandom_range(0, 1)), $urandom(), $urandom_range(0, 32'h0004_0000),
                     $urandom());
            push_random(45);
            drain();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
